/* sv/prc_pkg.sv */
// Shared types and constants for the packet receive checker.
// No dependencies; compile first.
`default_nettype none

package prc_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_CORRUPT      = 2'd0;
    localparam t_status ST_OUT_OF_ORDER = 2'd1;
    localparam t_status ST_OK           = 2'd2;

    // Control from the top level into the accumulator for one stage transaction.
    typedef struct packed {
        logic step;
        logic is_last;
    } t_acc_ctrl;

endpackage

`default_nettype wire

/* sv/prc_ifs.sv */
// Valid/ready channel interfaces for received words and check results.
// Depends on prc_pkg.
`default_nettype none

interface prc_rx_if
    import prc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic        [15:0] word;
    logic               odd_byte;
    logic               is_last;
    logic        [15:0] received_checksum;
    logic signed [31:0] expected_sequence;

    modport source (output valid, word, odd_byte, is_last, received_checksum,
                    expected_sequence, input ready);
    modport sink   (input valid, word, odd_byte, is_last, received_checksum,
                    expected_sequence, output ready);
endinterface

interface prc_res_if
    import prc_pkg::*;
();
    logic               valid;
    logic               ready;
    t_status            status;
    logic        [15:0] computed_checksum;
    logic signed [31:0] packet_sequence;

    modport source (output valid, status, computed_checksum, packet_sequence,
                    input ready);
    modport sink   (input valid, status, computed_checksum, packet_sequence,
                    output ready);
endinterface

`default_nettype wire

/* sv/prc_accum.sv */
// Ones-complement word sum and sequence capture for one packet.
// Depends on prc_pkg.
`default_nettype none

module prc_accum
    import prc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_acc_ctrl   i_ctrl,
    input  wire  [15:0] i_word,
    input  wire         i_odd_byte,
    output logic [15:0] o_sum,
    output logic [31:0] o_seq
);

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_BODY   = 2'd2;

    logic [15:0] r_sum, n_sum;
    logic [31:0] r_seq, n_seq;
    logic [1:0]  r_pos, n_pos;
    logic [15:0] val;
    logic [16:0] raw_sum;

    assign val     = i_odd_byte ? {8'h00, i_word[7:0]} : i_word;
    assign raw_sum = {1'b0, r_sum} + {1'b0, val};
    // end-around carry; a second carry cannot occur
    assign n_sum   = raw_sum[15:0] + {15'd0, raw_sum[16]};

    always_comb begin
        case (r_pos)
            POS_FIRST: begin
                n_seq = {r_seq[31:16], val};
                n_pos = POS_SECOND;
            end
            POS_SECOND: begin
                n_seq = {val, r_seq[15:0]};
                n_pos = POS_BODY;
            end
            default: begin
                n_seq = r_seq;
                n_pos = POS_BODY;
            end
        endcase
    end

    assign o_sum = n_sum;
    assign o_seq = n_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_seq <= '0;
            r_pos <= POS_FIRST;
        end else if (i_ctrl.step) begin
            if (i_ctrl.is_last) begin
                // clear for the next packet
                r_sum <= '0;
                r_seq <= '0;
                r_pos <= POS_FIRST;
            end else begin
                r_sum <= n_sum;
                r_seq <= n_seq;
                r_pos <= n_pos;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.step && i_ctrl.is_last |=> r_pos == POS_FIRST && r_sum == 16'd0)
        else $error("accumulator not cleared after last word");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == POS_BODY && i_ctrl.step && !i_ctrl.is_last |=> r_pos == POS_BODY)
        else $error("word position left saturation");

    a_low_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == POS_FIRST && i_ctrl.step && !i_ctrl.is_last
        |=> r_seq[15:0] == $past(val) && r_seq[31:16] == 16'd0)
        else $error("low sequence half not captured");

endmodule

`default_nettype wire

/* sv/packet_receive_checker.sv */
// Packet receive checker top level: input register, accumulator, result register.
// Depends on prc_pkg, prc_ifs (prc_rx_if, prc_res_if) and prc_accum.
//
// Usage:
//   i_rx carries one packet word per transaction (header words first, then
//   payload); a trailing lone byte comes with odd_byte set and only its low
//   byte counts. is_last marks the final word; received_checksum and
//   expected_sequence are sampled only with that word.
//   o_res delivers one transaction per packet: the complemented ones-complement
//   sum, the sequence taken little-endian from the first two words, and a
//   status (corrupt beats out of order beats ok).
//   A last word passes through the input register, then the result register,
//   on its way to o_res.
//   Throughput: one word per cycle, except while a last word waits for the
//   result register; one 16-bit end-around-carry add lies between the registers.
//   Reset clears the running sum, word position, captured sequence and both
//   valid flags; i_rx.ready is held low during reset and the block is ready
//   in the first cycle after reset.
//   Receiver stall: a pending result holds in the result register; non-last
//   words keep flowing, and a last word waits in the input register until the
//   result register frees, with i_rx.ready low for as long as it waits.
`default_nettype none

module packet_receive_checker
    import prc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    prc_rx_if.sink       i_rx,
    prc_res_if.source    o_res
);

    // input register
    logic               r_in_valid;
    logic        [15:0] r_in_word;
    logic               r_in_odd;
    logic               r_in_last;
    logic        [15:0] r_in_rx_sum;
    logic signed [31:0] r_in_exp_seq;

    // result register
    logic               r_out_valid;
    t_status            r_out_status;
    logic        [15:0] r_out_sum;
    logic signed [31:0] r_out_seq;

    logic        advance;
    logic        in_ready;
    t_acc_ctrl   acc_ctrl;
    logic [15:0] acc_sum;
    logic [31:0] acc_seq;
    logic [15:0] computed;
    t_status     n_status;

    // advance the held word unless it produces a result with nowhere to go
    assign advance  = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    // take nothing while reset is asserted
    assign in_ready = i_rst_n && (!r_in_valid || advance);
    assign i_rx.ready = in_ready;

    assign acc_ctrl.step    = advance;
    assign acc_ctrl.is_last = r_in_last;

    prc_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (acc_ctrl),
        .i_word     (r_in_word),
        .i_odd_byte (r_in_odd),
        .o_sum      (acc_sum),
        .o_seq      (acc_seq)
    );

    assign computed = ~acc_sum;

    always_comb begin
        if (computed != r_in_rx_sum) begin
            n_status = ST_CORRUPT;
        end else if (acc_seq != r_in_exp_seq) begin
            n_status = ST_OUT_OF_ORDER;
        end else begin
            n_status = ST_OK;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    // input register payload: load on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx.valid) begin
            r_in_word    <= i_rx.word;
            r_in_odd     <= i_rx.odd_byte;
            r_in_last    <= i_rx.is_last;
            r_in_rx_sum  <= i_rx.received_checksum;
            r_in_exp_seq <= i_rx.expected_sequence;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_status <= n_status;
            r_out_sum    <= computed;
            r_out_seq    <= acc_seq;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.status            = r_out_status;
    assign o_res.computed_checksum = r_out_sum;
    assign o_res.packet_sequence   = r_out_seq;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_in_last))
        else $error("result raised without a last word");

    a_hold_blocked_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && r_out_valid && !o_res.ready |-> !in_ready)
        else $error("input taken while last word is blocked");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_word) && $stable(r_in_last))
        else $error("stalled input word changed");

endmodule

`default_nettype wire
